// ----- hdl/counting_semaphore_wait_queue_unit_assert.svh -----
// Assertion macros for the counting semaphore wait queue unit.
`ifndef COUNTING_SEMAPHORE_WAIT_QUEUE_UNIT_ASSERT_SVH
`define COUNTING_SEMAPHORE_WAIT_QUEUE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// A condition that holds at every clock edge out of reset.
`define CSWQ_ASSERT_HOLD(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("cswq assertion failed");
// A condition that implies another in the same cycle.
`define CSWQ_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cswq assertion failed");
// A condition that implies another in the next cycle.
`define CSWQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cswq assertion failed");
`else
`define CSWQ_ASSERT_HOLD(label, clk, rst, cond)
`define CSWQ_ASSERT_IMPL(label, clk, rst, ante, cons)
`define CSWQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- hdl/cswq_pkg.sv -----
// Shared constants and types of the counting semaphore wait queue unit.
package cswq_pkg;

   localparam int MODE_W   = 2;
   localparam int ID_W     = 4;
   localparam int STATUS_W = 2;
   localparam int DATA_W   = 16;
   localparam int CSR_IDX_W = 2;

   // Operation codes of an input beat.
   localparam logic [MODE_W-1:0] MODE_POST   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_WAIT   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CANCEL = 2'd2;

   // Status codes of a result beat.
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_QUEUED   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_ALREADY  = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_COUNT     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAKE_EVENT    = 2'd2;

   // Sequencer states.
   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

endpackage

// ----- hdl/cswq_if.sv -----
// Request and response channel interfaces of the counting semaphore wait queue unit.
interface cswq_req_if;
   logic                        valid;
   logic                        ready;
   logic [cswq_pkg::MODE_W-1:0] mode;
   logic [cswq_pkg::ID_W-1:0]   requester_id;

   modport source (output valid, mode, requester_id, input ready);
   modport sink (input valid, mode, requester_id, output ready);
endinterface

interface cswq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [cswq_pkg::STATUS_W-1:0] status;
   logic                          wake_valid;
   logic [cswq_pkg::ID_W-1:0]     wake_id;
   logic [cswq_pkg::DATA_W-1:0]   wake_code;
   logic [cswq_pkg::DATA_W-1:0]   count_now;

   modport source (output valid, status, wake_valid, wake_id, wake_code, count_now,
                   input ready);
   modport sink (input valid, status, wake_valid, wake_id, wake_code, count_now,
                 output ready);
endinterface

// ----- hdl/counting_semaphore_wait_queue_unit.sv -----
// Counting semaphore with a first-in first-out queue of waiting requesters.
//
// Usage: each request beat carries a mode (post, wait or cancel) and a
// requester id; every request beat produces exactly one response beat with
// the status, an optional wake of the oldest waiter and the count afterwards.
// Configuration is to be written by the user through the csr_ port only
// while the unit is idle; the unit does not enforce this. Writing the
// initial count reloads the count and empties the waiter queue.
// A wait, a post that finds no waiter, a cancel of a requester that is not
// queued and an unused mode load the response register straight from the
// request. A post that wakes a waiter, and a cancel of a queued requester,
// walk the queue memory through its single read port and close the gap
// through its single write port, one slot a cycle. The unit takes no new
// request until the current one has finished.
//
// Reset clears the count, the queue and the response register; max_count
// resets to 1 and the wake event to 0. The response register holds a result
// until it is taken; while it is stalled no new request is accepted.
`include "counting_semaphore_wait_queue_unit_assert.svh"

module counting_semaphore_wait_queue_unit #(
   parameter int NUM_REQUESTERS = 16,
   parameter int COUNT_WIDTH    = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   cswq_req_if.sink                         req_chan,
   cswq_rsp_if.source                       rsp_chan,
   input  logic                             csr_we,
   input  logic [cswq_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cswq_pkg::DATA_W-1:0]      csr_data
);

   localparam int AW = $clog2(NUM_REQUESTERS);
   localparam int TW = $clog2(NUM_REQUESTERS + 1);

   // Configuration and semaphore state.
   logic [COUNT_WIDTH-1:0]     max_count_ff, max_count_in;
   logic [cswq_pkg::DATA_W-1:0] wake_event_ff, wake_event_in;
   logic [COUNT_WIDTH-1:0]     sem_count_ff, sem_count_in;
   logic [TW-1:0]              waiter_total_ff, waiter_total_in;
   logic [NUM_REQUESTERS-1:0]  queued_flags_ff, queued_flags_in;

   // Sequencer state.
   cswq_pkg::state_type        state_ff, state_in;
   logic [TW-1:0]              rd_ptr_ff, rd_ptr_in;
   logic                       pend_ff, pend_in;
   logic [AW-1:0]              pos_ff, pos_in;
   logic                       found_ff, found_in;
   logic                       op_post_ff, op_post_in;
   logic [cswq_pkg::ID_W-1:0]  target_ff, target_in;
   logic [cswq_pkg::ID_W-1:0]  rd_data_ff;

   // Response register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [cswq_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                          rsp_wake_valid_ff, rsp_wake_valid_in;
   logic [cswq_pkg::ID_W-1:0]     rsp_wake_id_ff, rsp_wake_id_in;
   logic [cswq_pkg::DATA_W-1:0]   rsp_wake_code_ff, rsp_wake_code_in;
   logic [cswq_pkg::DATA_W-1:0]   rsp_count_ff, rsp_count_in;

   // Queue memory of requester ids, oldest first.
   logic [cswq_pkg::ID_W-1:0]  slot_mem [NUM_REQUESTERS];

   logic                       req_ready;
   logic                       req_fire;
   logic                       rsp_free;
   logic                       id_in_range;
   logic                       flag_hit;
   logic                       scan_start;
   logic                       scan_end;
   logic                       match_now;
   logic                       mem_rd_en;
   logic                       mem_we;
   logic [AW-1:0]              mem_waddr;
   logic [cswq_pkg::ID_W-1:0]  mem_wdata;

   assign rsp_free    = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire    = req_chan.valid && req_ready;
   assign id_in_range = int'(req_chan.requester_id) < NUM_REQUESTERS;
   assign scan_end    = (state_ff == cswq_pkg::ST_SCAN) && !pend_ff &&
                        (rd_ptr_ff >= waiter_total_ff);

   // The queued flag of the requesting id.
   always_comb begin
      flag_hit = 1'b0;
      for (int i = 0; i < NUM_REQUESTERS; i++) begin
         if (i == int'(req_chan.requester_id)) begin
            flag_hit = queued_flags_ff[i];
         end
      end
   end

   // A post with waiters, or a cancel of a queued requester, walks the queue.
   always_comb begin
      scan_start = 1'b0;
      case (req_chan.mode)
         cswq_pkg::MODE_POST: begin
            scan_start = (waiter_total_ff != '0);
         end
         cswq_pkg::MODE_CANCEL: begin
            scan_start = id_in_range && flag_hit;
         end
         default: begin
            scan_start = 1'b0;
         end
      endcase
   end

   // The slot under test is the one removed: the head on a post, the id on a cancel.
   assign match_now = pend_ff && !found_ff &&
                      (op_post_ff ? (pos_ff == '0) : (rd_data_ff == target_ff));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cswq_pkg::ST_IDLE: begin
            if (req_fire && scan_start) begin
               state_in = cswq_pkg::ST_SCAN;
            end
         end
         cswq_pkg::ST_SCAN: begin
            if (scan_end && rsp_free) begin
               state_in = cswq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cswq_pkg::ST_IDLE;
         end
      endcase
   end

   // Handshake and memory port controls.
   always_comb begin
      req_ready = 1'b0;
      mem_rd_en = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = waiter_total_ff[AW-1:0];
      mem_wdata = req_chan.requester_id;
      case (state_ff)
         cswq_pkg::ST_IDLE: begin
            req_ready = rsp_free;
            // A wait that finds no unit appends its id at the tail.
            if (req_fire && (req_chan.mode == cswq_pkg::MODE_WAIT) && id_in_range &&
                !flag_hit && (sem_count_ff == '0) &&
                (int'(waiter_total_ff) < NUM_REQUESTERS)) begin
               mem_we = 1'b1;
            end
         end
         cswq_pkg::ST_SCAN: begin
            mem_rd_en = rd_ptr_ff < waiter_total_ff;
            // Behind the removed slot every id moves one place toward the head.
            if (pend_ff && found_ff) begin
               mem_we    = 1'b1;
               mem_waddr = pos_ff - AW'(1);
               mem_wdata = rd_data_ff;
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      logic load_rsp;
      logic wake;
      logic [cswq_pkg::STATUS_W-1:0] status;

      load_rsp        = 1'b0;
      wake            = 1'b0;
      status          = cswq_pkg::STATUS_OK;
      max_count_in    = max_count_ff;
      wake_event_in   = wake_event_ff;
      sem_count_in    = sem_count_ff;
      waiter_total_in = waiter_total_ff;
      queued_flags_in = queued_flags_ff;
      rd_ptr_in       = rd_ptr_ff;
      pend_in         = pend_ff;
      pos_in          = pos_ff;
      found_in        = found_ff;
      op_post_in      = op_post_ff;
      target_in       = target_ff;

      // Configuration writes; an index beyond the list is ignored.
      if (csr_we) begin
         case (csr_index)
            cswq_pkg::CSR_MAX_COUNT: begin
               max_count_in = COUNT_WIDTH'(csr_data);
            end
            cswq_pkg::CSR_INITIAL_COUNT: begin
               sem_count_in    = COUNT_WIDTH'(csr_data);
               waiter_total_in = '0;
               queued_flags_in = '0;
            end
            cswq_pkg::CSR_WAKE_EVENT: begin
               wake_event_in = csr_data;
            end
            default: begin
               max_count_in = max_count_ff;
            end
         endcase
      end

      // A new request beat.
      if (req_fire) begin
         rd_ptr_in  = '0;
         pend_in    = 1'b0;
         found_in   = 1'b0;
         op_post_in = (req_chan.mode == cswq_pkg::MODE_POST);
         target_in  = req_chan.requester_id;
         case (req_chan.mode)
            cswq_pkg::MODE_POST: begin
               if (waiter_total_ff == '0) begin
                  load_rsp = 1'b1;
                  if (sem_count_ff < max_count_ff) begin
                     sem_count_in = sem_count_ff + COUNT_WIDTH'(1);
                  end else begin
                     status = cswq_pkg::STATUS_OVERFLOW;
                  end
               end
            end
            cswq_pkg::MODE_WAIT: begin
               load_rsp = 1'b1;
               if (!id_in_range || flag_hit) begin
                  status = cswq_pkg::STATUS_ALREADY;
               end else if (sem_count_ff != '0) begin
                  sem_count_in = sem_count_ff - COUNT_WIDTH'(1);
               end else if (int'(waiter_total_ff) < NUM_REQUESTERS) begin
                  waiter_total_in = waiter_total_ff + TW'(1);
                  status          = cswq_pkg::STATUS_QUEUED;
                  for (int i = 0; i < NUM_REQUESTERS; i++) begin
                     if (i == int'(req_chan.requester_id)) begin
                        queued_flags_in[i] = 1'b1;
                     end
                  end
               end
            end
            cswq_pkg::MODE_CANCEL: begin
               load_rsp = !(id_in_range && flag_hit);
            end
            default: begin
               load_rsp = 1'b1;
            end
         endcase
      end

      // Queue walk: one read issued and one slot checked or moved per cycle.
      if (state_ff == cswq_pkg::ST_SCAN) begin
         pend_in = mem_rd_en;
         if (mem_rd_en) begin
            rd_ptr_in = rd_ptr_ff + TW'(1);
            pos_in    = rd_ptr_ff[AW-1:0];
         end
         if (match_now) begin
            found_in = 1'b1;
            if (op_post_ff) begin
               target_in = rd_data_ff;
            end
         end
         if (scan_end && rsp_free) begin
            load_rsp        = 1'b1;
            wake            = op_post_ff;
            waiter_total_in = waiter_total_ff - TW'(1);
            for (int i = 0; i < NUM_REQUESTERS; i++) begin
               if (i == int'(target_ff)) begin
                  queued_flags_in[i] = 1'b0;
               end
            end
         end
      end

      // Response register.
      rsp_valid_in      = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in     = rsp_status_ff;
      rsp_wake_valid_in = rsp_wake_valid_ff;
      rsp_wake_id_in    = rsp_wake_id_ff;
      rsp_wake_code_in  = rsp_wake_code_ff;
      rsp_count_in      = rsp_count_ff;
      if (load_rsp) begin
         rsp_valid_in      = 1'b1;
         rsp_status_in     = status;
         rsp_wake_valid_in = wake;
         rsp_wake_id_in    = wake ? target_ff : '0;
         rsp_wake_code_in  = wake ? wake_event_ff : '0;
         rsp_count_in      = cswq_pkg::DATA_W'(sem_count_in);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= cswq_pkg::ST_IDLE;
         max_count_ff    <= COUNT_WIDTH'(1);
         wake_event_ff   <= '0;
         sem_count_ff    <= '0;
         waiter_total_ff <= '0;
         queued_flags_ff <= '0;
         pend_ff         <= 1'b0;
         found_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         max_count_ff    <= max_count_in;
         wake_event_ff   <= wake_event_in;
         sem_count_ff    <= sem_count_in;
         waiter_total_ff <= waiter_total_in;
         queued_flags_ff <= queued_flags_in;
         pend_ff         <= pend_in;
         found_ff        <= found_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rd_ptr_ff         <= rd_ptr_in;
      pos_ff            <= pos_in;
      op_post_ff        <= op_post_in;
      target_ff         <= target_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_wake_valid_ff <= rsp_wake_valid_in;
      rsp_wake_id_ff    <= rsp_wake_id_in;
      rsp_wake_code_ff  <= rsp_wake_code_in;
      rsp_count_ff      <= rsp_count_in;
   end

   // Queue memory with one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_rd_en) begin
         rd_data_ff <= slot_mem[rd_ptr_ff[AW-1:0]];
      end
   end

   assign req_chan.ready      = req_ready;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.wake_valid = rsp_wake_valid_ff;
   assign rsp_chan.wake_id    = rsp_wake_id_ff;
   assign rsp_chan.wake_code  = rsp_wake_code_ff;
   assign rsp_chan.count_now  = rsp_count_ff;

   // The number of set queued flags equals the waiter count.
   `CSWQ_ASSERT_HOLD(a_total_matches_flags, clock, reset,
      $countones(queued_flags_ff) == int'(waiter_total_ff))
   // No request is taken while the queue is being walked.
   `CSWQ_ASSERT_IMPL(a_no_accept_in_scan, clock, reset,
      state_ff == cswq_pkg::ST_SCAN, !req_ready)
   // A wake only comes with a successful post.
   `CSWQ_ASSERT_IMPL(a_wake_is_ok, clock, reset,
      rsp_valid_ff && rsp_wake_valid_ff, rsp_status_ff == cswq_pkg::STATUS_OK)
   // A granted wait takes exactly one unit.
   `CSWQ_ASSERT_NEXT(a_wait_takes_unit, clock, reset,
      req_fire && (req_chan.mode == cswq_pkg::MODE_WAIT) && id_in_range && !flag_hit &&
         (sem_count_ff != '0) && !csr_we,
      sem_count_ff == $past(sem_count_ff) - COUNT_WIDTH'(1))

endmodule
